### rtl/core/preemptive_priority_scheduler_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the priority scheduler
// Shared property templates, all clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define PPS_ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("scheduler check failed");

// same-cycle implication
`define PPS_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// next-cycle implication
`define PPS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

### rtl/core/pps_pkg.sv
// ---------------------------------------------------------------------------
// pps_pkg
// Types and constants shared by the scheduler cells and the top level.
// ---------------------------------------------------------------------------
package pps_pkg;

  // index width covers the largest supported table (256 entries)
  localparam int PROC_IDX_W = 8;
  localparam int TIME_W     = 32;
  localparam int ARRIVAL_W  = 16;
  localparam int BURST_W    = 16;
  localparam int PRIO_W     = 8;
  localparam int RUN_ID_W   = 4;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 136;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // best candidate so far, handed from cell to cell
  typedef struct packed {
    logic                  found;
    logic [PRIO_W-1:0]     prio;
    logic [PROC_IDX_W-1:0] idx;
    logic [ARRIVAL_W-1:0]  arrival;
    logic [BURST_W-1:0]    burst;
    logic                  last;
  } pps_cand_t;

  // broadcast command to all cells
  typedef struct packed {
    logic                  load;
    logic                  run;
    logic [PROC_IDX_W-1:0] idx;
    logic [ARRIVAL_W-1:0]  arrival;
    logic [BURST_W-1:0]    burst;
    logic [PRIO_W-1:0]     prio;
  } pps_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_OUT
  } pps_state_t;

endpackage

### rtl/core/preemptive_priority_scheduler_unit.sv
// ---------------------------------------------------------------------------
// preemptive_priority_scheduler_unit
// Preemptive priority scheduler over a row of process cells.
// ---------------------------------------------------------------------------
// A word with tuser = 0 loads the next process entry (ignored once MAX_PROCS
// entries are loaded) and gives no output word. A word with tuser = 1 runs
// one time tick and gives exactly one output word. In a tick the best
// candidate travels down the chain of MAX_PROCS cells one cell per cycle,
// then the CALC state forms the times and the OUT state loads the output
// register once the output is free. Ties go to the lowest index; priority 0
// and zero-burst entries never run. running_id carries the low 4 bits of the
// process index. New words are accepted while the previous result waits.
`include "preemptive_priority_scheduler_unit_defines.svh"

module preemptive_priority_scheduler_unit #(
  parameter int MAX_PROCS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // arrival_time[15:0], burst_length[31:16], priority_level[39:32]
  input  logic [pps_pkg::IN_DATA_W-1:0]     s_tdata,
  // req_type
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // slot_time[31:0], running_id[35:32], finished[36], completion_time[68:37],
  // turnaround[100:69], waiting[132:101], all_done[133], zero pad [135:134]
  output logic [pps_pkg::OUT_DATA_W-1:0]    m_tdata,
  // idle
  output logic                              m_tuser
);
  import pps_pkg::*;

  localparam int CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int SCAN_W = $clog2(MAX_PROCS);

  pps_state_t state, state_next;

  logic [CNT_W-1:0]  loaded_count;
  logic [CNT_W-1:0]  done_count;
  logic [TIME_W-1:0] current_time;
  logic [SCAN_W-1:0] scan_cnt;

  pps_cand_t         chain [MAX_PROCS+1];
  pps_cand_t         best;
  logic [TIME_W-1:0] comp_r;
  logic [TIME_W-1:0] tat_r;

  pps_cmd_t cmd;
  logic     in_fire;
  logic     out_free;
  logic     out_load;
  logic     fin;
  logic [CNT_W-1:0] done_count_next;

  // output word fields
  logic [TIME_W-1:0]   slot_time;
  logic                idle;
  logic [RUN_ID_W-1:0] running_id;
  logic                finished;
  logic [TIME_W-1:0]   completion_time;
  logic [TIME_W-1:0]   turnaround;
  logic [TIME_W-1:0]   waiting;
  logic                all_done;

  assign chain[0] = '0;

  for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
    pps_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .now      (current_time),
      .cand_in  (chain[g]),
      .cand_out (chain[g+1])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && s_tuser == REQ_TICK) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_cnt == SCAN_W'(MAX_PROCS - 1)) state_next = ST_CALC;
      end
      ST_CALC: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    s_tready    = 1'b0;
    out_load    = 1'b0;
    cmd         = '0;
    cmd.arrival = s_tdata[15:0];
    cmd.burst   = s_tdata[31:16];
    cmd.prio    = s_tdata[39:32];
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid && (s_tuser == REQ_LOAD)
                   && (loaded_count < CNT_W'(MAX_PROCS));
        cmd.idx  = PROC_IDX_W'(loaded_count);
      end
      ST_OUT: begin
        out_load = out_free;
        cmd.run  = out_free && best.found;
        cmd.idx  = best.idx;
      end
      default: ;
    endcase
  end

  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign fin      = best.found && best.last;
  assign done_count_next = done_count + CNT_W'(fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      loaded_count <= '0;
      done_count   <= '0;
      current_time <= '0;
      scan_cnt     <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) loaded_count <= loaded_count + CNT_W'(1);
      if (in_fire) scan_cnt <= '0;
      else if (state == ST_SCAN) scan_cnt <= scan_cnt + SCAN_W'(1);
      if (out_load) begin
        done_count   <= done_count_next;
        current_time <= current_time + TIME_W'(1);
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // winner and derived times
  always_ff @(posedge clk) begin
    if (state == ST_CALC) begin
      best   <= chain[MAX_PROCS];
      comp_r <= current_time + TIME_W'(1);
      tat_r  <= current_time + TIME_W'(1) - TIME_W'(chain[MAX_PROCS].arrival);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      slot_time       <= current_time;
      idle            <= !best.found;
      running_id      <= best.found ? RUN_ID_W'(best.idx) : '0;
      finished        <= fin;
      completion_time <= fin ? comp_r : '0;
      turnaround      <= fin ? tat_r : '0;
      waiting         <= fin ? (tat_r - TIME_W'(best.burst)) : '0;
      all_done        <= (done_count_next == loaded_count);
    end
  end

  assign m_tdata = {2'b00, all_done, waiting, turnaround, completion_time,
                    finished, running_id, slot_time};
  assign m_tuser = idle;

  `PPS_ASSERT_ALWAYS(a_done_le_loaded, done_count <= loaded_count)
  `PPS_ASSERT_NEXT(a_time_step, out_load, current_time == TIME_W'($past(current_time) + 1))
  `PPS_ASSERT_IMPLY(a_idle_quiet, m_tvalid && m_tuser, running_id == '0 && !finished)

endmodule

### rtl/core/pps_cell.sv
// ---------------------------------------------------------------------------
// pps_cell
// One process entry. Compares its own entry against the candidate coming
// from the previous cell and registers the better one toward the next cell.
// ---------------------------------------------------------------------------
module pps_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  pps_pkg::pps_cmd_t              cmd,
  input  logic [pps_pkg::TIME_W-1:0]     now,
  input  pps_pkg::pps_cand_t             cand_in,
  output pps_pkg::pps_cand_t             cand_out
);
  import pps_pkg::*;

  logic                 valid;
  logic [ARRIVAL_W-1:0] arrival;
  logic [BURST_W-1:0]   remaining;
  logic [BURST_W-1:0]   burst;
  logic [PRIO_W-1:0]    prio;

  logic      sel;
  logic      arrived;
  logic      take;
  pps_cand_t own;

  assign sel     = (cmd.idx == PROC_IDX_W'(CELL_IDX));
  // arrival is 16 bits, so any time at or above 2^16 means it has arrived
  assign arrived = (|now[TIME_W-1:ARRIVAL_W]) || (arrival <= now[ARRIVAL_W-1:0]);
  // strict compare keeps the lower index on a tie
  assign take    = valid && arrived && (remaining != '0) && (prio > cand_in.prio);

  always_comb begin
    own.found   = 1'b1;
    own.prio    = prio;
    own.idx     = PROC_IDX_W'(CELL_IDX);
    own.arrival = arrival;
    own.burst   = burst;
    own.last    = (remaining == BURST_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.load && sel) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && sel) begin
      arrival   <= cmd.arrival;
      burst     <= cmd.burst;
      remaining <= cmd.burst;
      prio      <= cmd.prio;
    end else if (cmd.run && sel) begin
      remaining <= remaining - BURST_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    cand_out <= take ? own : cand_in;
  end

endmodule
